FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define VDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vde check failed");

// Next-cycle implication, reset masked.
`define VDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vde check failed");

`endif

FILE: sv/vde_pkg.sv
package vde_pkg;

    localparam int ELEM_W      = 16;
    localparam int OP_W        = ELEM_W + 1;          // element or difference
    localparam int PROD_W      = 2 * OP_W;
    localparam int ACC_W       = 48;
    localparam int MAX_DIM     = 1024;
    localparam int CNT_W       = $clog2(MAX_DIM + 1);
    localparam int NORM_SHIFT  = ELEM_W - 2;
    localparam int EUC_SHIFT   = 36 - 2 * ELEM_W;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int FRAC_W      = 30;
    localparam int QUO_W       = ACC_W + FRAC_W;
    localparam int OUT_W       = 32;
    localparam logic [OUT_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [OUT_W-1:0] OUT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic start;
        logic clear;
    } t_mac_ctl;

endpackage

FILE: sv/vector_distance_engine.sv
// Per element pair: four products through one shared 17x17 multiplier, then
//   the last accumulate; not ready until they are done.
// Last pair: euclidean adds a 32-step square root; cosine adds two 32-step
//   roots, one 32x32 multiply and a 78-step restoring divide, unless a norm is zero.
// Result sits in an output register; a new pair is taken while it waits.
// Reset (i_rst_n low, synchronous): accumulators, counts, metric cleared.
module vector_distance_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pair stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic        i_s_tlast,   // last_pair
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] distance, Q16.16
    output logic [1:0]  o_m_tuser,   // [0] zero_norm, [1] overlong
    // metric register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data   // metric_select: 0 cosine, 1 euclidean
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_SQA  = 4'd3;
    localparam logic [3:0] S_SQB  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DST  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_SQE  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam int AW = vde_pkg::ACC_W;
    localparam int SW = vde_pkg::SQ_W;
    localparam int OW = vde_pkg::OUT_W;

    logic [3:0]              r_state, n_state;
    logic                    r_metric, r_last;
    vde_pkg::t_mac_ctl       w_mac_ctl;
    logic                    w_mac_done, w_ovl;
    logic [AW-1:0]           w_dot, w_na, w_nb, w_dd, w_mag;
    logic                    w_sq_start, w_sq_done;
    logic [SW-1:0]           w_sq_x;
    logic [vde_pkg::ROOT_W-1:0] w_root, r_ra, r_rb;
    logic [SW-1:0]           r_den;
    logic                    w_div_start, w_div_done, w_rem_nz;
    logic [vde_pkg::QUO_W-1:0] w_quo;
    logic [OW-1:0]           w_qs, r_dist;
    logic [OW:0]             w_neg_sum, w_pos_q;
    logic                    r_zn;
    logic                    w_fire, w_accept;
    logic                    r_m_valid;
    logic [OW-1:0]           r_m_data;
    logic [1:0]              r_m_user;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    // result leaves FIN once the output register is free
    assign w_fire      = (r_state == S_FIN) && (!r_m_valid || i_m_tready);

    assign w_mac_ctl.start = w_accept;
    assign w_mac_ctl.clear = w_fire;

    vde_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_elem_a   (i_s_tdata[15:0]),
        .i_elem_b   (i_s_tdata[31:16]),
        .o_done     (w_mac_done),
        .o_dot      (w_dot),
        .o_norm_a   (w_na),
        .o_norm_b   (w_nb),
        .o_diff_sq  (w_dd),
        .o_overlong (w_ovl)
    );

    // square root operand: norm A, norm B or the difference sum, prescaled
    always_comb begin
        w_sq_start = 1'b0;
        w_sq_x     = {{(SW-AW){1'b0}}, w_na} << vde_pkg::NORM_SHIFT;
        if (r_state == S_CHK) begin
            if (r_metric) begin
                w_sq_start = 1'b1;
                w_sq_x     = {{(SW-AW){1'b0}}, w_dd} << vde_pkg::EUC_SHIFT;
            end else if (w_na != '0 && w_nb != '0) begin
                w_sq_start = 1'b1;
            end
        end else if (r_state == S_SQA && w_sq_done) begin
            w_sq_start = 1'b1;
            w_sq_x     = {{(SW-AW){1'b0}}, w_nb} << vde_pkg::NORM_SHIFT;
        end
    end

    vde_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_x     (w_sq_x),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // |dot|; the most negative value maps to 2^47 by itself
    assign w_mag       = w_dot[AW-1] ? (AW'(0) - w_dot) : w_dot;
    assign w_div_start = (r_state == S_DST);

    vde_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_mag),
        .i_den    (r_den),
        .o_done   (w_div_done),
        .o_quo    (w_quo),
        .o_rem_nz (w_rem_nz)
    );

    // quotient is |dot|/den in Q.30; saturate, then 1 +/- it
    assign w_qs      = (w_quo > vde_pkg::QUO_W'(vde_pkg::OUT_MAX)) ? vde_pkg::OUT_MAX
                                                                    : w_quo[OW-1:0];
    assign w_neg_sum = {1'b0, vde_pkg::ONE_Q16} + {1'b0, w_qs};
    assign w_pos_q   = {1'b0, w_qs} + (OW+1)'(w_rem_nz);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_MAC;
            S_MAC:  if (w_mac_done) n_state = r_last ? S_CHK : S_IDLE;
            S_CHK:  begin
                if (r_metric)            n_state = S_SQE;
                else if (w_sq_start)     n_state = S_SQA;
                else                     n_state = S_FIN;
            end
            S_SQA:  if (w_sq_done) n_state = S_SQB;
            S_SQB:  if (w_sq_done) n_state = S_MUL;
            S_MUL:  n_state = S_DST;
            S_DST:  n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_FIN;
            S_SQE:  if (w_sq_done) n_state = S_FIN;
            S_FIN:  if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_metric  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_metric <= i_cfg_data[0];
            end
            if (w_fire) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_s_tlast;
        end
        if (r_state == S_CHK) begin
            r_dist <= vde_pkg::ONE_Q16;
            r_zn   <= !r_metric;
        end
        if (r_state == S_SQA && w_sq_done) begin
            r_ra <= w_root;
        end
        if (r_state == S_SQB && w_sq_done) begin
            r_rb <= w_root;
        end
        if (r_state == S_MUL) begin
            r_den <= r_ra * r_rb;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_zn <= 1'b0;
            if (w_dot[AW-1]) begin
                r_dist <= w_neg_sum[OW] ? vde_pkg::OUT_MAX : w_neg_sum[OW-1:0];
            end else if (w_pos_q >= {1'b0, vde_pkg::ONE_Q16}) begin
                r_dist <= '0;
            end else begin
                r_dist <= vde_pkg::ONE_Q16 - w_pos_q[OW-1:0];
            end
        end
        if (r_state == S_SQE && w_sq_done) begin
            r_zn   <= 1'b0;
            r_dist <= w_root;
        end
        if (w_fire) begin
            r_m_data <= r_dist;
            r_m_user <= {w_ovl, r_zn};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
endmodule

FILE: sv/vde_mac.sv
module vde_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  vde_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [vde_pkg::ELEM_W-1:0]    i_elem_a,
    input  logic signed [vde_pkg::ELEM_W-1:0]    i_elem_b,
    output logic                                 o_done,
    output logic [vde_pkg::ACC_W-1:0]            o_dot,
    output logic [vde_pkg::ACC_W-1:0]            o_norm_a,
    output logic [vde_pkg::ACC_W-1:0]            o_norm_b,
    output logic [vde_pkg::ACC_W-1:0]            o_diff_sq,
    output logic                                 o_overlong
);
    localparam logic [1:0] SEL_AB = 2'd0;
    localparam logic [1:0] SEL_AA = 2'd1;
    localparam logic [1:0] SEL_BB = 2'd2;
    localparam logic [1:0] SEL_DD = 2'd3;

    logic signed [vde_pkg::OP_W-1:0]   r_a, r_b, w_d, w_x, w_y;
    logic signed [vde_pkg::PROD_W-1:0] r_prod;
    logic [vde_pkg::ACC_W-1:0]         w_prod_ext;
    logic [1:0]                        r_step, r_psel;
    logic                              r_run, r_pv, r_skip;
    logic [vde_pkg::CNT_W-1:0]         r_cnt;
    logic [vde_pkg::ACC_W-1:0]         r_dot, r_na, r_nb, r_dd;
    logic                              r_ovl;

    assign w_d = r_a - r_b;

    always_comb begin
        case (r_step)
            SEL_AB:  begin w_x = r_a; w_y = r_b; end
            SEL_AA:  begin w_x = r_a; w_y = r_a; end
            SEL_BB:  begin w_x = r_b; w_y = r_b; end
            default: begin w_x = w_d; w_y = w_d; end
        endcase
    end

    assign w_prod_ext = {{(vde_pkg::ACC_W-vde_pkg::PROD_W){r_prod[vde_pkg::PROD_W-1]}}, r_prod};
    assign o_done     = (r_pv && r_psel == SEL_DD) || r_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pv   <= 1'b0;
            r_skip <= 1'b0;
            r_step <= SEL_AB;
            r_psel <= SEL_AB;
            r_cnt  <= '0;
            r_ovl  <= 1'b0;
            r_dot  <= '0;
            r_na   <= '0;
            r_nb   <= '0;
            r_dd   <= '0;
        end else begin
            r_skip <= 1'b0;
            r_pv   <= r_run;
            if (r_run) begin
                r_prod <= w_x * w_y;
                r_psel <= r_step;
                r_step <= r_step + 2'd1;
                if (r_step == SEL_DD) begin
                    r_run <= 1'b0;
                end
            end
            if (r_pv) begin
                unique case (r_psel)
                    SEL_AB:  r_dot <= r_dot + w_prod_ext;
                    SEL_AA:  r_na  <= r_na + w_prod_ext;
                    SEL_BB:  r_nb  <= r_nb + w_prod_ext;
                    default: r_dd  <= r_dd + w_prod_ext;
                endcase
            end
            if (i_ctl.clear) begin
                r_cnt <= '0;
                r_ovl <= 1'b0;
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_dd  <= '0;
            end else if (i_ctl.start) begin
                if (r_cnt < vde_pkg::CNT_W'(vde_pkg::MAX_DIM)) begin
                    r_a    <= {i_elem_a[vde_pkg::ELEM_W-1], i_elem_a};
                    r_b    <= {i_elem_b[vde_pkg::ELEM_W-1], i_elem_b};
                    r_run  <= 1'b1;
                    r_step <= SEL_AB;
                    r_cnt  <= r_cnt + 1'b1;
                end else begin
                    r_ovl  <= 1'b1;
                    r_skip <= 1'b1;
                end
            end
        end
    end

    assign o_dot      = r_dot;
    assign o_norm_a   = r_na;
    assign o_norm_b   = r_nb;
    assign o_diff_sq  = r_dd;
    assign o_overlong = r_ovl;
endmodule

FILE: sv/vde_sqrt.sv
module vde_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vde_pkg::SQ_W-1:0]     i_x,
    output logic                         o_done,
    output logic [vde_pkg::ROOT_W-1:0]   o_root
);
    localparam int IT_W = $clog2(vde_pkg::ROOT_W);

    logic [vde_pkg::SQ_W-1:0] r_x, r_res, r_bit, w_t;
    logic [IT_W-1:0]          r_cnt;
    logic                     r_busy, r_done;

    assign w_t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IT_W'(vde_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one result bit per cycle, restoring form
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= vde_pkg::SQ_W'(1) << (vde_pkg::SQ_W - 2);
        end else if (r_busy) begin
            if (r_x >= w_t) begin
                r_x   <= r_x - w_t;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[vde_pkg::ROOT_W-1:0];
endmodule

FILE: sv/vde_div.sv
module vde_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vde_pkg::ACC_W-1:0]    i_num,
    input  logic [vde_pkg::SQ_W-1:0]     i_den,
    output logic                         o_done,
    output logic [vde_pkg::QUO_W-1:0]    o_quo,
    output logic                         o_rem_nz
);
    localparam int IT_W = $clog2(vde_pkg::QUO_W);

    logic [vde_pkg::SQ_W-1:0]  r_rem, r_den, w_sh;
    logic [vde_pkg::QUO_W-1:0] r_quo;
    logic [IT_W-1:0]           r_cnt;
    logic                      r_busy, r_done, w_ge;

    assign w_sh = {r_rem[vde_pkg::SQ_W-2:0], r_quo[vde_pkg::QUO_W-1]};
    assign w_ge = (w_sh >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IT_W'(vde_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= {i_num, {vde_pkg::FRAC_W{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - r_den) : w_sh;
            r_quo <= {r_quo[vde_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_quo;
    assign o_rem_nz = (r_rem != '0);
endmodule

FILE: sv/vde_checker.sv
`include "assert_macros.svh"

module vde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    // a transfer in starts the pair's work: not ready on the next cycle
    `VDE_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // zero-norm results always read exactly 1.0
    `VDE_ASSERT_NOW(a_zero_norm_one, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == 32'h0001_0000)

    // stalled result holds
    `VDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
endmodule

bind vector_distance_engine vde_checker u_vde_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
